@@ rtl/core/nptq_pkg.sv @@
// ----------------------------------------------------------------------------
// nptq_pkg
// Shared types and constants of the nested priority task queue.
// ----------------------------------------------------------------------------
package nptq_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned PRIO_W  = 14;
  localparam int unsigned QCNT_W  = 5;
  localparam int unsigned ERR_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_COMPLETE = 2'd2
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 2'd0,
    ERR_QUEUE_FULL = 2'd1,
    ERR_NEST_FULL  = 2'd2,
    ERR_NO_TASK    = 2'd3
  } err_e;

  // One queued task
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } qent_t;

  localparam int unsigned QENT_W = $bits(qent_t);

endpackage

@@ rtl/core/nptq_in_if.sv @@
// ----------------------------------------------------------------------------
// nptq_in_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface nptq_in_if;
  logic                         valid;
  logic                         ready;
  logic [nptq_pkg::CMD_W-1:0]   command;
  logic [nptq_pkg::ID_W-1:0]    task_id;
  logic [nptq_pkg::PRIO_W-1:0]  priority_req;

  modport source (output valid, output command, output task_id, output priority_req,
                  input ready);
  modport sink   (input valid, input command, input task_id, input priority_req,
                  output ready);
endinterface

@@ rtl/core/nptq_out_if.sv @@
// ----------------------------------------------------------------------------
// nptq_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface nptq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         run_valid;
  logic [nptq_pkg::ID_W-1:0]    run_task_id;
  logic [nptq_pkg::PRIO_W-1:0]  run_priority;
  logic [nptq_pkg::PRIO_W-1:0]  current_level;
  logic [nptq_pkg::QCNT_W-1:0]  queued_count;
  logic [nptq_pkg::ERR_W-1:0]   error_code;

  modport source (output valid, output run_valid, output run_task_id, output run_priority,
                  output current_level, output queued_count, output error_code,
                  input ready);
  modport sink   (input valid, input run_valid, input run_task_id, input run_priority,
                  input current_level, input queued_count, input error_code,
                  output ready);
endinterface

@@ rtl/core/nested_priority_task_queue.sv @@
// ----------------------------------------------------------------------------
// nested_priority_task_queue
// Sorted task queue in a circular RAM plus a RAM stack of preempted levels.
// ----------------------------------------------------------------------------
// Accepted commands: an error, a no-op or an add to an empty queue go straight
// to S_OUT; dispatch and complete pass S_DISP or S_CMPL; any other add passes
// S_SHIFT, one RAM read-modify-write per cycle for each queued entry the new
// task moves past, and may end in S_INS. A new command is taken the cycle after
// the result is loaded into the output register, which waits while it is held.
// Reset: queue and stack empty, running level IDLE_LEVEL; RAMs are not cleared.
module nested_priority_task_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NEST_DEPTH  = 8,
  parameter int unsigned IDLE_LEVEL  = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nptq_in_if.sink     cmd_i,
  nptq_out_if.source  res_o
);

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int unsigned NW  = $clog2(NEST_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_INS   = 6'b000100,
    S_DISP  = 6'b001000,
    S_CMPL  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [nptq_pkg::ID_W-1:0]       tid_q, tid_d;
  logic [nptq_pkg::PRIO_W-1:0]     prq_q, prq_d;
  logic [QCW-1:0]                  pos_q, pos_d;
  logic [QAW-1:0]                  head_q, head_d;
  logic [QCW-1:0]                  count_q, count_d;
  logic [nptq_pkg::PRIO_W-1:0]     level_q, level_d;
  logic [NW-1:0]                   nest_q, nest_d;
  logic [NW-1:0]                   nest_dec;

  // pending result
  logic                            rv_q, rv_d;
  logic [nptq_pkg::ID_W-1:0]       rid_q, rid_d;
  logic [nptq_pkg::PRIO_W-1:0]     rprio_q, rprio_d;
  nptq_pkg::err_e                  err_q, err_d;

  // output register
  logic                            ov_q, ov_d;
  logic                            orv_q, orv_d;
  logic [nptq_pkg::ID_W-1:0]       orid_q, orid_d;
  logic [nptq_pkg::PRIO_W-1:0]     orprio_q, orprio_d;
  logic [nptq_pkg::PRIO_W-1:0]     olevel_q, olevel_d;
  logic [nptq_pkg::QCNT_W-1:0]     ocount_q, ocount_d;
  nptq_pkg::err_e                  oerr_q, oerr_d;

  // RAM ports
  logic                            q_we;
  logic [QAW-1:0]                  q_waddr, q_raddr;
  nptq_pkg::qent_t                 q_wdata, q_rdata, new_ent;
  logic                            s_we;
  logic [SAW-1:0]                  s_waddr, s_raddr;
  logic [nptq_pkg::PRIO_W-1:0]     s_wdata, s_rdata;

  // logical queue position to RAM address
  function automatic logic [QAW-1:0] phys(input logic [QAW-1:0] head,
                                          input logic [QCW-1:0] idx);
    logic [QCW:0] sum;
    sum = (QCW+1)'(head) + (QCW+1)'(idx);
    if (sum >= (QCW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (QCW+1)'(QUEUE_DEPTH);
    end
    return sum[QAW-1:0];
  endfunction

  nptq_ram #(.Width(nptq_pkg::QENT_W), .Depth(QUEUE_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  nptq_ram #(.Width(nptq_pkg::PRIO_W), .Depth(NEST_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign nest_dec      = nest_q - NW'(1);
  assign new_ent.id    = tid_q;
  assign new_ent.prio  = prq_q;
  assign cmd_i.ready   = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    tid_d    = tid_q;
    prq_d    = prq_q;
    pos_d    = pos_q;
    head_d   = head_q;
    count_d  = count_q;
    level_d  = level_q;
    nest_d   = nest_q;
    rv_d     = rv_q;
    rid_d    = rid_q;
    rprio_d  = rprio_q;
    err_d    = err_q;
    ov_d     = ov_q & ~res_o.ready;
    orv_d    = orv_q;
    orid_d   = orid_q;
    orprio_d = orprio_q;
    olevel_d = olevel_q;
    ocount_d = ocount_q;
    oerr_d   = oerr_q;

    q_we    = 1'b0;
    q_waddr = phys(head_q, pos_q);
    q_wdata = new_ent;
    q_raddr = '0;
    s_we    = 1'b0;
    s_waddr = nest_q[SAW-1:0];
    s_wdata = level_q;
    s_raddr = nest_dec[SAW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          tid_d   = cmd_i.task_id;
          prq_d   = cmd_i.priority_req;
          rv_d    = 1'b0;
          rid_d   = '0;
          rprio_d = '0;
          err_d   = nptq_pkg::ERR_OK;
          state_d = S_OUT;
          case (nptq_pkg::cmd_e'(cmd_i.command))
            nptq_pkg::CMD_ADD: begin
              if (count_q == QCW'(QUEUE_DEPTH)) begin
                err_d = nptq_pkg::ERR_QUEUE_FULL;
              end else if (count_q == '0) begin
                q_we         = 1'b1;
                q_waddr      = head_q;
                q_wdata.id   = cmd_i.task_id;
                q_wdata.prio = cmd_i.priority_req;
                count_d      = count_q + QCW'(1);
              end else begin
                // walk back from the tail, moving larger priorities up one slot
                pos_d   = count_q;
                q_raddr = phys(head_q, count_q - QCW'(1));
                state_d = S_SHIFT;
              end
            end
            nptq_pkg::CMD_DISPATCH: begin
              if (count_q != '0) begin
                q_raddr = head_q;
                state_d = S_DISP;
              end
            end
            nptq_pkg::CMD_COMPLETE: begin
              if (nest_q == '0) begin
                err_d = nptq_pkg::ERR_NO_TASK;
              end else begin
                state_d = S_CMPL;
              end
            end
            default: ;
          endcase
        end
      end

      S_SHIFT: begin
        q_we = 1'b1;
        if (q_rdata.prio > prq_q) begin
          q_wdata = q_rdata;
          pos_d   = pos_q - QCW'(1);
          if (pos_q == QCW'(1)) begin
            state_d = S_INS;
          end else begin
            q_raddr = phys(head_q, QCW'(pos_q - QCW'(2)));
          end
        end else begin
          count_d = count_q + QCW'(1);
          state_d = S_OUT;
        end
      end

      S_INS: begin
        q_we    = 1'b1;
        count_d = count_q + QCW'(1);
        state_d = S_OUT;
      end

      S_DISP: begin
        if (q_rdata.prio < level_q) begin
          if (nest_q == NW'(NEST_DEPTH)) begin
            err_d = nptq_pkg::ERR_NEST_FULL;
          end else begin
            rv_d    = 1'b1;
            rid_d   = q_rdata.id;
            rprio_d = q_rdata.prio;
            head_d  = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
            count_d = count_q - QCW'(1);
            s_we    = 1'b1;
            nest_d  = nest_q + NW'(1);
            level_d = q_rdata.prio;
          end
        end
        state_d = S_OUT;
      end

      S_CMPL: begin
        level_d = s_rdata;
        nest_d  = nest_dec;
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!ov_q || res_o.ready) begin
          ov_d     = 1'b1;
          orv_d    = rv_q;
          orid_d   = rid_q;
          orprio_d = rprio_q;
          olevel_d = level_q;
          ocount_d = nptq_pkg::QCNT_W'(count_q);
          oerr_d   = err_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      level_q <= nptq_pkg::PRIO_W'(IDLE_LEVEL);
      nest_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      level_q <= level_d;
      nest_q  <= nest_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q    <= tid_d;
    prq_q    <= prq_d;
    pos_q    <= pos_d;
    rv_q     <= rv_d;
    rid_q    <= rid_d;
    rprio_q  <= rprio_d;
    err_q    <= err_d;
    orv_q    <= orv_d;
    orid_q   <= orid_d;
    orprio_q <= orprio_d;
    olevel_q <= olevel_d;
    ocount_q <= ocount_d;
    oerr_q   <= oerr_d;
  end

  assign res_o.valid         = ov_q;
  assign res_o.run_valid     = orv_q;
  assign res_o.run_task_id   = orid_q;
  assign res_o.run_priority  = orprio_q;
  assign res_o.current_level = olevel_q;
  assign res_o.queued_count  = ocount_q;
  assign res_o.error_code    = oerr_q;

endmodule

@@ rtl/core/nptq_ram.sv @@
// ----------------------------------------------------------------------------
// nptq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nptq_ram #(
  parameter int unsigned Width = 22,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks nested_priority_task_queue against a transaction-level predictor.
// A directed opening walks the stable insert order, the preemption compare
// and the empty stack case. Random segments then fill the queue, nest
// dispatches down to a full stack, drain it, and throw in noise, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CMD_W  = nptq_pkg::CMD_W;
  localparam int unsigned ID_W   = nptq_pkg::ID_W;
  localparam int unsigned PRIO_W = nptq_pkg::PRIO_W;
  localparam int unsigned QCNT_W = nptq_pkg::QCNT_W;
  localparam int unsigned ERR_W  = nptq_pkg::ERR_W;

  localparam int unsigned QUEUE_SLOTS  = 16;
  localparam int unsigned NEST_SLOTS   = 8;
  localparam logic [PRIO_W-1:0] IDLE_PRIO = 14'd9999;
  localparam logic [PRIO_W-1:0] PRIO_MAX  = 14'h3FFF;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;  // unused code, block ignores it
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned TAIL_ITEMS   = 200;
  localparam int unsigned DRAIN_EVERY  = 500;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned HIGH_LIMIT   = 4;

  typedef struct packed {
    logic              run_valid;
    logic [ID_W-1:0]   run_id;
    logic [PRIO_W-1:0] run_prio;
    logic [PRIO_W-1:0] level;
    logic [QCNT_W-1:0] count;
    logic [ERR_W-1:0]  err;
  } task_result_t;

  typedef enum int {MIX_PLAIN, MIX_FILL, MIX_DRAIN, MIX_NEST, MIX_NOISE} mix_e;

  class task_queue_scoreboard;
    nptq_pkg::qent_t   waiting[QUEUE_SLOTS];
    int unsigned       n_waiting;
    logic [PRIO_W-1:0] level;
    logic [PRIO_W-1:0] saved[NEST_SLOTS];
    int unsigned       depth;
    task_result_t      pending[$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       dispatched;
    int unsigned       err_seen[4];

    function new();
      n_waiting  = 0;
      level      = IDLE_PRIO;
      depth      = 0;
      mismatches = 0;
      checked    = 0;
      dispatched = 0;
      foreach (err_seen[i]) err_seen[i] = 0;
    endfunction

    // tasks that can never run from the idle level
    function int unsigned high_waiting();
      int unsigned n;
      n = 0;
      for (int unsigned i = 0; i < n_waiting; i++)
        if (waiting[i].prio >= IDLE_PRIO) n++;
      return n;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      task_result_t r;
      int unsigned pos;
      r = '0;
      r.err = nptq_pkg::ERR_OK;
      case (cmd)
        nptq_pkg::CMD_ADD: begin
          if (n_waiting >= QUEUE_SLOTS) begin
            r.err = nptq_pkg::ERR_QUEUE_FULL;
          end else begin
            // lands behind every entry of equal or smaller priority
            pos = 0;
            while (pos < n_waiting && waiting[pos].prio <= prio) pos++;
            for (int unsigned i = n_waiting; i > pos; i--) waiting[i] = waiting[i-1];
            waiting[pos].id   = id;
            waiting[pos].prio = prio;
            n_waiting++;
          end
        end
        nptq_pkg::CMD_DISPATCH: begin
          if (n_waiting > 0 && waiting[0].prio < level) begin
            if (depth >= NEST_SLOTS) begin
              r.err = nptq_pkg::ERR_NEST_FULL;
            end else begin
              r.run_valid = 1'b1;
              r.run_id    = waiting[0].id;
              r.run_prio  = waiting[0].prio;
              for (int unsigned i = 1; i < n_waiting; i++) waiting[i-1] = waiting[i];
              n_waiting--;
              saved[depth] = level;
              depth++;
              level = r.run_prio;
            end
          end
        end
        nptq_pkg::CMD_COMPLETE: begin
          if (depth == 0) begin
            r.err = nptq_pkg::ERR_NO_TASK;
          end else begin
            depth--;
            level = saved[depth];
          end
        end
        default: ;
      endcase
      r.level = level;
      r.count = QCNT_W'(n_waiting);
      pending.push_back(r);
    endfunction

    function void check_result(task_result_t got);
      task_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing pending: run=%0b id=%0d prio=%0d lvl=%0d cnt=%0d err=%0d",
                   $time, got.run_valid, got.run_id, got.run_prio, got.level, got.count,
                   got.err);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.run_valid !== want.run_valid || got.run_id !== want.run_id ||
          got.run_prio !== want.run_prio || got.level !== want.level ||
          got.count !== want.count || got.err !== want.err) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] mismatch on result %0d", $time, checked);
          $display("  expected run=%0b id=%0d prio=%0d lvl=%0d cnt=%0d err=%0d",
                   want.run_valid, want.run_id, want.run_prio, want.level, want.count,
                   want.err);
          $display("  actual   run=%0b id=%0d prio=%0d lvl=%0d cnt=%0d err=%0d",
                   got.run_valid, got.run_id, got.run_prio, got.level, got.count, got.err);
        end
      end else begin
        if (got.run_valid) dispatched++;
        err_seen[got.err]++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;
  int unsigned gap_pct = 20;
  int unsigned stall_left = 0;
  int unsigned items_sent = 0;
  task_queue_scoreboard sb;

  nptq_in_if  cmd_if ();
  nptq_out_if res_if ();

  nested_priority_task_queue uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  always #6 clk = ~clk;

  // receiver: holds ready low in random stall bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
        res_if.ready <= 1'b0;
        stall_left   <= $urandom_range(8);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
      sb.check_result('{res_if.run_valid, res_if.run_task_id, res_if.run_priority,
                        res_if.current_level, res_if.queued_count, res_if.error_code});
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL nested_priority_task_queue");
    $finish;
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [PRIO_W-1:0] prio);
    @(negedge clk);
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= cmd;
    cmd_if.task_id      <= id;
    cmd_if.priority_req <= prio;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    sb.note_command(cmd, id, prio);
    items_sent++;
  endtask

  task automatic maybe_gap();
    if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct)
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk);
        cmd_if.valid <= 1'b0;
      end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 35) return PRIO_W'($urandom_range(15));
    if (sel < 75) return PRIO_W'($urandom_range(IDLE_PRIO - 1));
    if (sel < 85) begin
      case ($urandom_range(4))
        0: return '0;
        1: return PRIO_MAX;
        2: return PRIO_W'(IDLE_PRIO - 1);
        3: return IDLE_PRIO;
        default: return PRIO_W'(IDLE_PRIO + 1);
      endcase
    end
    // cap tasks that would never drain from idle, or the queue clogs for good
    if (sb.high_waiting() < HIGH_LIMIT) return PRIO_W'($urandom_range(PRIO_MAX));
    return PRIO_W'($urandom_range(IDLE_PRIO - 1));
  endfunction

  task automatic pick_item(mix_e mix, output logic [CMD_W-1:0] cmd,
                           output logic [ID_W-1:0] id, output logic [PRIO_W-1:0] prio);
    int unsigned sel;
    int unsigned step;
    sel  = $urandom_range(99);
    id   = ID_W'($urandom_range(255));
    prio = pick_prio();
    case (mix)
      MIX_FILL:  cmd = (sel < 80) ? nptq_pkg::CMD_ADD : nptq_pkg::CMD_DISPATCH;
      MIX_DRAIN: cmd = (sel < 45) ? nptq_pkg::CMD_DISPATCH :
                       (sel < 90) ? nptq_pkg::CMD_COMPLETE : nptq_pkg::CMD_ADD;
      MIX_NEST: begin
        // keep feeding tasks just above the running level and preempt with them
        if (sb.level == 0 || sel < 8) begin
          cmd = nptq_pkg::CMD_COMPLETE;
        end else if (sb.n_waiting > 0 && sb.waiting[0].prio < sb.level) begin
          cmd = nptq_pkg::CMD_DISPATCH;
        end else if (sb.n_waiting >= QUEUE_SLOTS) begin
          cmd = nptq_pkg::CMD_COMPLETE;
        end else begin
          cmd  = nptq_pkg::CMD_ADD;
          step = $urandom_range(1, (sb.level < 40) ? sb.level : 40);
          prio = PRIO_W'(sb.level - step);
        end
      end
      MIX_NOISE: begin
        cmd  = CMD_W'($urandom_range(3));
        prio = PRIO_W'($urandom_range(PRIO_MAX));
      end
      default: begin
        if (sel < 40)      cmd = nptq_pkg::CMD_ADD;
        else if (sel < 75) cmd = nptq_pkg::CMD_DISPATCH;
        else if (sel < 95) cmd = nptq_pkg::CMD_COMPLETE;
        else               cmd = CMD_RESERVED;
      end
    endcase
  endtask

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    mix_e        mix;
    int unsigned n;
    int unsigned seg;
    int unsigned seg_len;

    sb = new();
    rst_n               = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.command      = nptq_pkg::CMD_ADD;
    cmd_if.task_id      = '0;
    cmd_if.priority_req = '0;
    res_if.ready        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening
    send_item(nptq_pkg::CMD_COMPLETE, 8'd0, '0);     // nothing to complete
    send_item(nptq_pkg::CMD_DISPATCH, 8'd0, '0);     // empty queue
    send_item(CMD_RESERVED, 8'hFF, PRIO_MAX);
    send_item(nptq_pkg::CMD_ADD, 8'hFF, PRIO_MAX);
    send_item(nptq_pkg::CMD_ADD, 8'h00, '0);
    send_item(nptq_pkg::CMD_ADD, 8'hA5, IDLE_PRIO);  // equal to idle, never runs from idle
    send_item(nptq_pkg::CMD_ADD, 8'h01, PRIO_W'(IDLE_PRIO - 1));
    send_item(nptq_pkg::CMD_ADD, 8'h02, PRIO_W'(IDLE_PRIO - 1));  // equal priorities keep order
    send_item(nptq_pkg::CMD_ADD, 8'h03, '0);
    maybe_gap();
    send_item(nptq_pkg::CMD_DISPATCH, 8'd0, '0);
    send_item(nptq_pkg::CMD_DISPATCH, 8'd0, '0);     // head equals running level
    send_item(nptq_pkg::CMD_COMPLETE, 8'd0, '0);
    send_item(nptq_pkg::CMD_DISPATCH, 8'd0, '0);
    send_item(nptq_pkg::CMD_COMPLETE, 8'd0, '0);
    send_item(nptq_pkg::CMD_DISPATCH, 8'd0, '0);
    send_item(nptq_pkg::CMD_DISPATCH, 8'd0, '0);
    send_item(nptq_pkg::CMD_COMPLETE, 8'd0, '0);
    send_item(nptq_pkg::CMD_DISPATCH, 8'd0, '0);
    send_item(nptq_pkg::CMD_COMPLETE, 8'd0, '0);
    send_item(nptq_pkg::CMD_DISPATCH, 8'd0, '0);     // head at idle level, no preemption
    send_item(nptq_pkg::CMD_ADD, 8'h5A, 14'h2AAA);
    send_item(nptq_pkg::CMD_ADD, 8'hC3, 14'h1555);
    wait_drained();

    n   = 0;
    seg = 0;
    while (n < RANDOM_ITEMS) begin
      seg_len = $urandom_range(15, 60);
      case (seg)
        0: mix = MIX_FILL;
        1: mix = MIX_NEST;
        default: mix = mix_e'($urandom_range(4));
      endcase
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      for (int unsigned j = 0; j < seg_len && n < RANDOM_ITEMS; j++) begin
        if (RANDOM_ITEMS - n <= TAIL_ITEMS) calm = 1'b1;
        if (n != 0 && n % DRAIN_EVERY == 0 && j == 0) wait_drained();
        pick_item(mix, cmd, id, prio);
        maybe_gap();
        send_item(cmd, id, prio);
        n++;
      end
      seg++;
    end

    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Covered %0d transactions in %0d segments, %0d results checked, %0d dispatches.",
             items_sent, seg, sb.checked, sb.dispatched);
    $display("Errors seen: queue full %0d, stack full %0d, no task %0d; mismatches %0d.",
             sb.err_seen[nptq_pkg::ERR_QUEUE_FULL], sb.err_seen[nptq_pkg::ERR_NEST_FULL],
             sb.err_seen[nptq_pkg::ERR_NO_TASK], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASS nested_priority_task_queue");
    else
      $display("FAIL nested_priority_task_queue");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/nptq_pkg.sv
rtl/core/nptq_in_if.sv
rtl/core/nptq_out_if.sv
rtl/core/nptq_ram.sv
rtl/core/nested_priority_task_queue.sv
dv/testbench.sv
